FILE: design/eaq_pkg.sv
// ----------------------------------------------------------------------------
// eaq_pkg: shared constants and types for the Euler-to-quaternion block
// Arctangent table, CORDIC gain, word widths, channel payloads.
// ----------------------------------------------------------------------------
package eaq_pkg;

    localparam int ANG_W     = 16;
    localparam int Q_W       = 16;
    localparam int CW        = 33;   // CORDIC x/y word, Q.30 plus guard
    localparam int ZW        = 33;   // angle accumulator, pi/2^31 units
    localparam int TRIG_W    = 17;   // rounded Q.15 cos/sin
    localparam int TABLE_LEN = 24;
    localparam int STAGES_DEFAULT = 16;

    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [Q_W-1:0]   quat_t;
    typedef logic signed [CW-1:0]    cword_t;
    typedef logic signed [ZW-1:0]    zword_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    // input request: yaw, pitch, roll
    typedef struct packed {
        angle_t yaw_angle;
        angle_t pitch_angle;
        angle_t roll_angle;
    } euler_req_t;

    // output request: w, x, y, z in Q1.14
    typedef struct packed {
        quat_t quat_w;
        quat_t quat_x;
        quat_t quat_y;
        quat_t quat_z;
    } quat_req_t;

    typedef struct packed {
        cword_t x;
        cword_t y;
        zword_t z;
    } rot_t;

    typedef struct packed {
        rot_t yaw;
        rot_t pitch;
        rot_t roll;
    } lane3_t;

    function automatic zword_t atan_entry(input logic [4:0] idx);
        zword_t t;
        case (idx)
            5'd0:  t = 33'sd536870912;
            5'd1:  t = 33'sd316933406;
            5'd2:  t = 33'sd167458907;
            5'd3:  t = 33'sd85004756;
            5'd4:  t = 33'sd42667331;
            5'd5:  t = 33'sd21354465;
            5'd6:  t = 33'sd10679838;
            5'd7:  t = 33'sd5340245;
            5'd8:  t = 33'sd2670163;
            5'd9:  t = 33'sd1335087;
            5'd10: t = 33'sd667544;
            5'd11: t = 33'sd333772;
            5'd12: t = 33'sd166886;
            5'd13: t = 33'sd83443;
            5'd14: t = 33'sd41722;
            5'd15: t = 33'sd20861;
            5'd16: t = 33'sd10430;
            5'd17: t = 33'sd5215;
            5'd18: t = 33'sd2608;
            5'd19: t = 33'sd1304;
            5'd20: t = 33'sd652;
            5'd21: t = 33'sd326;
            5'd22: t = 33'sd163;
            5'd23: t = 33'sd81;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

FILE: design/eaq_stream_if.sv
// ----------------------------------------------------------------------------
// eaq_stream_if: valid/ready channel carrying a payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface eaq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/eaq_cordic_cell.sv
// ----------------------------------------------------------------------------
// eaq_cordic_cell: one CORDIC rotation stage for all three angles
// Registered; advances when the chain advances.
// ----------------------------------------------------------------------------
module eaq_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           clk,
    input  logic           en,
    input  eaq_pkg::lane3_t din,
    output eaq_pkg::lane3_t dout
);
    import eaq_pkg::*;

    lane3_t result_reg;
    lane3_t result_next;

    localparam zword_t ATAN = atan_entry(5'(STAGE));

    function automatic rot_t rotate(input rot_t r);
        rot_t   o;
        cword_t dx;
        cword_t dy;
        dx = r.y >>> STAGE;
        dy = r.x >>> STAGE;
        if (!r.z[ZW-1])
        begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - ATAN;
        end
        else
        begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + ATAN;
        end
        return o;
    endfunction

    always_comb
    begin
        result_next.yaw   = rotate(din.yaw);
        result_next.pitch = rotate(din.pitch);
        result_next.roll  = rotate(din.roll);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign dout = result_reg;
endmodule

FILE: design/eaq_combine.sv
// ----------------------------------------------------------------------------
// eaq_combine: rounds cos/sin and forms the four quaternion components
// Three register stages: pair products, triple products, round/saturate.
// ----------------------------------------------------------------------------
module eaq_combine (
    input  logic            clk,
    input  logic [2:0]      en,
    input  eaq_pkg::lane3_t din,
    output eaq_pkg::quat_t  quat_w,
    output eaq_pkg::quat_t  quat_x,
    output eaq_pkg::quat_t  quat_y,
    output eaq_pkg::quat_t  quat_z
);
    import eaq_pkg::*;

    typedef logic signed [2*TRIG_W-1:0] pair_t;
    typedef logic signed [3*TRIG_W-1:0] trip_t;
    typedef logic signed [3*TRIG_W:0]   sum_t;

    trig_t cy, sy, cp, sp, cr, sr;
    trig_t cy_reg, sy_reg;
    pair_t pcc_reg, pcs_reg, psc_reg, pss_reg;   // roll x pitch
    trip_t t_reg [8];
    quat_t q_reg [4];
    sum_t  s [4];
    quat_t q_next [4];

    function automatic trig_t rnd15(input cword_t v);
        cword_t t;
        t = v + cword_t'(16384);
        return trig_t'(t >>> 15);
    endfunction

    function automatic quat_t to_q14(input sum_t v);
        sum_t r;
        r = (v + (sum_t'(1) <<< 30)) >>> 31;
        if (r > sum_t'(16384))
            return quat_t'(16384);
        else if (r < -sum_t'(16384))
            return -quat_t'(16384);
        return quat_t'(r);
    endfunction

    always_comb
    begin
        cy = rnd15(din.yaw.x);
        sy = rnd15(din.yaw.y);
        cp = rnd15(din.pitch.x);
        sp = rnd15(din.pitch.y);
        cr = rnd15(din.roll.x);
        sr = rnd15(din.roll.y);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pcc_reg <= pair_t'(cr) * pair_t'(cp);
            pcs_reg <= pair_t'(cr) * pair_t'(sp);
            psc_reg <= pair_t'(sr) * pair_t'(cp);
            pss_reg <= pair_t'(sr) * pair_t'(sp);
            cy_reg  <= cy;
            sy_reg  <= sy;
        end
        if (en[1])
        begin
            t_reg[0] <= trip_t'(pcc_reg) * trip_t'(cy_reg);
            t_reg[1] <= trip_t'(pss_reg) * trip_t'(sy_reg);
            t_reg[2] <= trip_t'(psc_reg) * trip_t'(cy_reg);
            t_reg[3] <= trip_t'(pcs_reg) * trip_t'(sy_reg);
            t_reg[4] <= trip_t'(pcs_reg) * trip_t'(cy_reg);
            t_reg[5] <= trip_t'(psc_reg) * trip_t'(sy_reg);
            t_reg[6] <= trip_t'(pcc_reg) * trip_t'(sy_reg);
            t_reg[7] <= trip_t'(pss_reg) * trip_t'(cy_reg);
        end
        if (en[2])
            q_reg <= q_next;
    end

    always_comb
    begin
        s[0] = sum_t'(t_reg[0]) + sum_t'(t_reg[1]);
        s[1] = sum_t'(t_reg[2]) - sum_t'(t_reg[3]);
        s[2] = sum_t'(t_reg[4]) + sum_t'(t_reg[5]);
        s[3] = sum_t'(t_reg[6]) - sum_t'(t_reg[7]);
        for (int k = 0; k < 4; k++)
            q_next[k] = to_q14(s[k]);
    end

    assign quat_w = q_reg[0];
    assign quat_x = q_reg[1];
    assign quat_y = q_reg[2];
    assign quat_z = q_reg[3];
endmodule

FILE: design/euler_angles_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion: ZYX Euler angles to unit quaternion
//
//   channel   dir   payload                                  accept
//   in_req    in    yaw_angle, pitch_angle, roll_angle       valid & ready
//   out_req   out   quat_w, quat_x, quat_y, quat_z (Q1.14)   valid & ready
//
// One request per cycle while the pipeline is not stalled. Stages: a load
// stage, one cell per CORDIC stage up to TABLE_LEN (all three angles rotate
// side by side), then pair products, triple products and round/saturate.
// A stage loads when it is empty or when the stage ahead of it loads; the
// last stage loads when it is empty or the output is taken. Bubbles squeeze
// out under stall, and the input is ready while any stage is free.
// Reset clears only the valid bits of the stages; no state between requests.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion #(
    parameter int CORDIC_STAGES = eaq_pkg::STAGES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    eaq_stream_if.sink   in_req,
    eaq_stream_if.source out_req
);
    import eaq_pkg::*;

    // stages beyond the table do nothing, so they are left out
    localparam int NS   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int NPIP = NS + 4;   // load + cells + three combine stages

    logic [NPIP-1:0] vld_reg;
    logic [NPIP-1:0] vld_next;
    logic [NPIP-1:0] adv;            // stage k loads this cycle

    lane3_t load_reg;
    lane3_t load_next;
    lane3_t chain [NS+1];

    // a stage may load when it is empty or its content moves on
    always_comb
    begin
        adv[NPIP-1] = !vld_reg[NPIP-1] || out_req.ready;
        for (int k = NPIP-2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign in_req.ready = adv[0];

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
            vld_next[0] = in_req.valid;
        for (int k = 1; k < NPIP; k++)
            if (adv[k])
                vld_next[k] = vld_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // half angle: input * 2^15 in pi/2^31 units
    function automatic rot_t seed(input angle_t a);
        rot_t r;
        r.x = GAIN_Q30;
        r.y = '0;
        r.z = zword_t'(a) <<< 15;
        return r;
    endfunction

    always_comb
    begin
        load_next.yaw   = seed(in_req.payload.yaw_angle);
        load_next.pitch = seed(in_req.payload.pitch_angle);
        load_next.roll  = seed(in_req.payload.roll_angle);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            load_reg <= load_next;
    end

    assign chain[0] = load_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        eaq_cordic_cell #(.STAGE(g)) u_cell (
            .clk  (clk),
            .en   (adv[g+1]),
            .din  (chain[g]),
            .dout (chain[g+1])
        );
    end

    eaq_combine u_combine (
        .clk    (clk),
        .en     (adv[NPIP-1:NPIP-3]),
        .din    (chain[NS]),
        .quat_w (out_req.payload.quat_w),
        .quat_x (out_req.payload.quat_x),
        .quat_y (out_req.payload.quat_y),
        .quat_z (out_req.payload.quat_z)
    );

    assign out_req.valid = vld_reg[NPIP-1];
endmodule
